@@ design/bmq_pkg.sv @@
package bmq_pkg;

    // Fixed field widths of the ports.
    localparam int DATA_W  = 32;
    localparam int TICKS_W = 32;
    localparam int TASK_W  = 3;
    localparam int WAKE_W  = 8;
    localparam int FILL_W  = 5;

    // Default sizes of the storage.
    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;
    localparam int TASK_COUNT_DEF = 8;

    // Capacity register value after reset.
    localparam logic [FILL_W-1:0] CAP_RESET = 5'd16;

    // Command codes.
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_WOULD_BLOCK = 2'd1,
        ST_TIMEOUT     = 2'd2,
        ST_BLOCKED     = 2'd3
    } status_t;

endpackage

@@ design/bmq_store.sv @@
module bmq_store #(
    parameter int DEPTH      = bmq_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = bmq_pkg::ITEM_WIDTH_DEF,
    parameter int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [PTR_W-1:0]      waddr,
    input  logic [ITEM_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [PTR_W-1:0]      raddr,
    output logic [ITEM_WIDTH-1:0] rdata
);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rdata_reg;

    // One write port and one read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/blocking_message_queue.sv @@
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+--------------------------------
// request   | cmd, task_req, is_retry, nonblocking,           | taken when start is high and
//           | wait_forever, wait_ticks, send_data             | busy is low
// result    | status, recv_data, wake_mask, block_forever,    | done high for one cycle; the
//           | block_ticks, fill_count, is_empty, is_full      | beat cannot be held off
// config    | cfg_we, cfg_wdata (capacity)                    | written on any edge with cfg_we
//
// Each request beat produces exactly one result beat, in the cycle after it is taken.
// A new request may be taken on every cycle; the latency is set by the one-cycle
// read of the message memory, which a receive needs before its data can be shown.
// Reset is asynchronous and active low. It clears the pointers, the count and both
// wait masks, and sets the capacity to sixteen. The message memory is not cleared.
// busy is high during reset and in the first cycle after reset is released.
// The receiver cannot stall, so nothing inside ever waits on the result side.
module blocking_message_queue #(
    parameter int DEPTH      = bmq_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = bmq_pkg::ITEM_WIDTH_DEF,
    parameter int TASK_COUNT = bmq_pkg::TASK_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [bmq_pkg::FILL_W-1:0]   cfg_wdata,

    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [bmq_pkg::TASK_W-1:0]   task_req,
    input  logic                         is_retry,
    input  logic                         nonblocking,
    input  logic                         wait_forever,
    input  logic [bmq_pkg::TICKS_W-1:0]  wait_ticks,
    input  logic [bmq_pkg::DATA_W-1:0]   send_data,

    output logic                         done,
    output logic [1:0]                   status,
    output logic [bmq_pkg::DATA_W-1:0]   recv_data,
    output logic [bmq_pkg::WAKE_W-1:0]   wake_mask,
    output logic                         block_forever,
    output logic [bmq_pkg::TICKS_W-1:0]  block_ticks,
    output logic [bmq_pkg::FILL_W-1:0]   fill_count,
    output logic                         is_empty,
    output logic                         is_full
);

    import bmq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Control state.
    logic                  busy_reg;
    logic [FILL_W-1:0]     cap_reg;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]     count_reg, count_next;
    logic [TASK_COUNT-1:0] send_wait_reg, send_wait_next;
    logic [TASK_COUNT-1:0] recv_wait_reg, recv_wait_next;
    logic                  done_reg;

    // Result payload.
    status_t               status_reg, status_next;
    logic                  recv_ok_reg;
    logic [WAKE_W-1:0]     wake_reg, wake_next;
    logic                  bforever_reg, bforever_next;
    logic [TICKS_W-1:0]    bticks_reg, bticks_next;
    logic [FILL_W-1:0]     fill_reg;
    logic                  empty_reg, empty_next;
    logic                  full_reg, full_next;

    logic                  accept;
    logic                  is_send;
    logic [FILL_W-1:0]     cap_eff;
    logic [TASK_COUNT-1:0] task_bit;
    logic [TASK_COUNT-1:0] send_wait_cl;
    logic [TASK_COUNT-1:0] recv_wait_cl;
    logic                  send_ok;
    logic                  recv_ok;
    logic [ITEM_WIDTH-1:0] mem_rdata;

    assign accept  = start && !busy_reg;
    assign is_send = (cmd == CMD_SEND);

    // Capacity in use: zero counts as one, anything above the depth as the depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = FILL_W'(1);
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            cap_eff = FILL_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // A task index beyond the task count has no wait bit.
    always_comb
    begin
        task_bit = '0;
        if (32'(task_req) < TASK_COUNT)
        begin
            task_bit = TASK_COUNT'(1) << task_req;
        end
    end

    // A retry drops the task's own wait bit before anything else is decided.
    assign send_wait_cl = (is_retry && is_send)  ? (send_wait_reg & ~task_bit) : send_wait_reg;
    assign recv_wait_cl = (is_retry && !is_send) ? (recv_wait_reg & ~task_bit) : recv_wait_reg;

    assign send_ok = is_send && (count_reg < cap_eff);
    assign recv_ok = !is_send && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        send_wait_next = send_wait_cl;
        recv_wait_next = recv_wait_cl;
        status_next    = ST_OK;
        wake_next      = '0;
        bforever_next  = 1'b0;
        bticks_next    = '0;

        if (send_ok)
        begin
            // Pointers wrap at the capacity in use, also when left past it by a
            // capacity change.
            wr_ptr_next    = (32'(wr_ptr_reg) + 1 >= 32'(cap_eff)) ? '0 : wr_ptr_reg + 1'b1;
            count_next     = count_reg + 1'b1;
            wake_next      = WAKE_W'(recv_wait_cl);
            recv_wait_next = '0;
        end
        else if (recv_ok)
        begin
            rd_ptr_next    = (32'(rd_ptr_reg) + 1 >= 32'(cap_eff)) ? '0 : rd_ptr_reg + 1'b1;
            count_next     = count_reg - 1'b1;
            wake_next      = WAKE_W'(send_wait_cl);
            send_wait_next = '0;
        end
        else if (nonblocking)
        begin
            status_next = ST_WOULD_BLOCK;
        end
        else if (!wait_forever && (wait_ticks == '0))
        begin
            status_next = ST_TIMEOUT;
        end
        else
        begin
            // The task parks on the mask of its own side.
            status_next = ST_BLOCKED;
            if (is_send)
            begin
                send_wait_next = send_wait_cl | task_bit;
            end
            else
            begin
                recv_wait_next = recv_wait_cl | task_bit;
            end
            if (wait_forever)
            begin
                bforever_next = 1'b1;
            end
            else
            begin
                bticks_next = wait_ticks;
            end
        end

        empty_next = (count_next == '0);
        full_next  = (count_next >= cap_eff);
    end

    // The message memory: a send writes at the write pointer in the accept cycle,
    // a receive reads at the read pointer and the data arrives with the result.
    // A send and a receive never share one beat, and a write is complete before
    // any later read, so no forwarding is needed.
    bmq_store #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH),
        .PTR_W      (PTR_W)
    ) u_store (
        .clk   (clk),
        .we    (accept && send_ok),
        .waddr (wr_ptr_reg),
        .wdata (ITEM_WIDTH'(send_data)),
        .re    (accept && recv_ok),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            cap_reg       <= CAP_RESET;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            send_wait_reg <= '0;
            recv_wait_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            done_reg <= accept;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                wr_ptr_reg    <= wr_ptr_next;
                rd_ptr_reg    <= rd_ptr_next;
                count_reg     <= count_next;
                send_wait_reg <= send_wait_next;
                recv_wait_reg <= recv_wait_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            recv_ok_reg  <= recv_ok;
            wake_reg     <= wake_next;
            bforever_reg <= bforever_next;
            bticks_reg   <= bticks_next;
            fill_reg     <= count_next;
            empty_reg    <= empty_next;
            full_reg     <= full_next;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign recv_data     = recv_ok_reg ? DATA_W'(mem_rdata) : '0;
    assign wake_mask     = wake_reg;
    assign block_forever = bforever_reg;
    assign block_ticks   = bticks_reg;
    assign fill_count    = fill_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

endmodule

@@ design/bmq_checker.sv @@
module bmq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [1:0]                   status,
    input logic [bmq_pkg::DATA_W-1:0]   recv_data,
    input logic [bmq_pkg::WAKE_W-1:0]   wake_mask,
    input logic                         block_forever,
    input logic [bmq_pkg::TICKS_W-1:0]  block_ticks,
    input logic [bmq_pkg::FILL_W-1:0]   fill_count,
    input logic                         is_empty
);

    import bmq_pkg::*;

    // Every request beat gives its result beat on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request beat without result beat");

    // Only a successful attempt moves data or wakes anyone.
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((wake_mask == '0) && (recv_data == '0)))
        else $error("failed attempt carries data or wake mask");

    // Wait details appear only with a blocked status, and never both kinds.
    a_wait_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_BLOCKED)) |-> (!block_forever && (block_ticks == '0)))
        else $error("wait fields set without blocked status");

    a_wait_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (done && block_forever) |-> (block_ticks == '0))
        else $error("unbounded wait carries ticks");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (fill_count == '0)))
        else $error("empty flag disagrees with fill count");

endmodule

bind blocking_message_queue bmq_checker u_bmq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .recv_data     (recv_data),
    .wake_mask     (wake_mask),
    .block_forever (block_forever),
    .block_ticks   (block_ticks),
    .fill_count    (fill_count),
    .is_empty      (is_empty)
);

@@ dv/blocking_message_queue_tb.sv @@
`timescale 1ns / 1ps

module blocking_message_queue_tb;

    import bmq_pkg::*;

    // The mailbox under test uses the default sizes of the package.
    localparam int SLOTS = DEPTH_DEF;
    localparam int SLOT_W = $clog2(SLOTS);

    // One mailbox attempt as it appears on the request ports. The member order
    // matches the port concatenation used by the monitor.
    typedef struct packed {
        logic        cmd;
        logic [2:0]  task_id;
        logic        retry;
        logic        nonblk;
        logic        unbounded;
        logic [31:0] ticks;
        logic [31:0] data;
    } attempt_t;

    // The answer the mailbox gives to one attempt.
    typedef struct packed {
        status_t     status;
        logic [31:0] rdata;
        logic [7:0]  wake;
        logic        unbounded;
        logic [31:0] wait_left;
        logic [4:0]  fill;
        logic        empty_flag;
        logic        full_flag;
    } reply_t;

    // The driver works through a list of these. Besides attempts, the list holds
    // capacity writes and pauses in which the driver lets the mailbox go quiet.
    typedef enum logic [1:0] {
        ENTRY_ATTEMPT,
        ENTRY_CAPACITY,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        attempt_t    attempt;
        int unsigned gap;
        logic [4:0]  cap_value;
    } entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = CMD_SEND;
    logic [2:0]  task_req = '0;
    logic        is_retry = 1'b0;
    logic        nonblocking = 1'b0;
    logic        wait_forever = 1'b0;
    logic [31:0] wait_ticks = '0;
    logic [31:0] send_data = '0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] recv_data;
    logic [7:0]  wake_mask;
    logic        block_forever;
    logic [31:0] block_ticks;
    logic [4:0]  fill_count;
    logic        is_empty;
    logic        is_full;

    blocking_message_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .task_req     (task_req),
        .is_retry     (is_retry),
        .nonblocking  (nonblocking),
        .wait_forever (wait_forever),
        .wait_ticks   (wait_ticks),
        .send_data    (send_data),
        .done         (done),
        .status       (status),
        .recv_data    (recv_data),
        .wake_mask    (wake_mask),
        .block_forever(block_forever),
        .block_ticks  (block_ticks),
        .fill_count   (fill_count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Mailbox predictor. It keeps its own copy of the ring buffer, both wait
    // masks and the capacity register, and is advanced once per accepted beat.
    // ------------------------------------------------------------------------
    logic [31:0] msg_store [SLOTS];
    int unsigned wr_idx = 0;
    int unsigned rd_idx = 0;
    int unsigned held = 0;
    logic [7:0]  send_waiting = '0;
    logic [7:0]  recv_waiting = '0;
    logic [4:0]  cap_reg = CAP_RESET;

    // Pointers wrap at the capacity in use, so a pointer left past a shrunken
    // capacity falls back to slot zero the next time it moves.
    function automatic int unsigned next_slot(int unsigned p, int unsigned limit);
        return (p + 1 >= limit) ? 0 : p + 1;
    endfunction

    function automatic reply_t predict_attempt(attempt_t a);
        reply_t      r;
        int unsigned limit;
        logic [7:0]  own_bit;
        r = '0;
        // A capacity of zero acts as one, anything above the depth as the depth.
        limit = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
        own_bit = 8'b1 << a.task_id;
        // A task coming back after a wake-up first leaves the wait mask of its side.
        if (a.retry)
        begin
            if (a.cmd == CMD_SEND)
                send_waiting &= ~own_bit;
            else
                recv_waiting &= ~own_bit;
        end
        if (a.cmd == CMD_SEND && held < limit)
        begin
            msg_store[SLOT_W'(wr_idx)] = a.data;
            wr_idx = next_slot(wr_idx, limit);
            held++;
            r.wake = recv_waiting;
            recv_waiting = '0;
            r.status = ST_OK;
        end
        else if (a.cmd == CMD_RECV && held > 0)
        begin
            r.rdata = msg_store[SLOT_W'(rd_idx)];
            rd_idx = next_slot(rd_idx, limit);
            held--;
            r.wake = send_waiting;
            send_waiting = '0;
            r.status = ST_OK;
        end
        else if (a.nonblk)
        begin
            r.status = ST_WOULD_BLOCK;
        end
        else if (!a.unbounded && a.ticks == 0)
        begin
            // Zero ticks left means the wait has already run out, even on a
            // first attempt.
            r.status = ST_TIMEOUT;
        end
        else
        begin
            if (a.cmd == CMD_SEND)
                send_waiting |= own_bit;
            else
                recv_waiting |= own_bit;
            r.status = ST_BLOCKED;
            if (a.unbounded)
                r.unbounded = 1'b1;
            else
                r.wait_left = a.ticks;
        end
        r.fill = 5'(held);
        r.empty_flag = (held == 0);
        r.full_flag = (held >= limit);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard state shared by the driver, the monitor and the run control.
    // ------------------------------------------------------------------------
    entry_t      work_list[$];
    reply_t      expected_replies[$];
    logic        beat_taken = 1'b0;
    int unsigned quiet_edges = 0;
    int unsigned gap_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned replies_checked = 0;
    int unsigned capacity_writes = 0;
    int unsigned status_tally [4] = '{0, 0, 0, 0};

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Inputs change on the falling edge only. A beat stays on the ports
    // until the monitor reports it taken; start is computed once per edge so it
    // never sees two assignments in the same step.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic drive_start;
        logic drive_we;
        drive_start = start;
        drive_we = 1'b0;
        if (rst_n)
        begin
            if (start && beat_taken)
                drive_start = 1'b0;
            // Count edges with nothing on the ports and nothing owed by the mailbox.
            if (!drive_start && expected_replies.size() == 0)
                quiet_edges++;
            else
                quiet_edges = 0;
            if (!drive_start && work_list.size() > 0)
            begin
                case (work_list[0].kind)
                    ENTRY_ATTEMPT:
                    begin
                        if (gap_count < work_list[0].gap)
                        begin
                            gap_count++;
                        end
                        else
                        begin
                            cmd <= work_list[0].attempt.cmd;
                            task_req <= work_list[0].attempt.task_id;
                            is_retry <= work_list[0].attempt.retry;
                            nonblocking <= work_list[0].attempt.nonblk;
                            wait_forever <= work_list[0].attempt.unbounded;
                            wait_ticks <= work_list[0].attempt.ticks;
                            send_data <= work_list[0].attempt.data;
                            drive_start = 1'b1;
                            gap_count = 0;
                            void'(work_list.pop_front());
                        end
                    end
                    ENTRY_CAPACITY:
                    begin
                        // The last result has arrived and the ports have stayed quiet
                        // after it, so the mailbox is idle for the write.
                        if (quiet_edges >= 2)
                        begin
                            drive_we = 1'b1;
                            cfg_wdata <= work_list[0].cap_value;
                            void'(work_list.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet_edges >= 1)
                            void'(work_list.pop_front());
                    end
                endcase
            end
        end
        start <= drive_start;
        cfg_we <= drive_we;
    end

    // ------------------------------------------------------------------------
    // Monitor. Samples on the rising edge: first retires the result beat of the
    // cycle, then applies a capacity write, then predicts a newly taken beat.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t want;
        reply_t next_reply;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with no attempt outstanding, status %0d",
                             $time, status);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("recv_data", want.rdata, recv_data);
                    check_field("wake_mask", 32'(want.wake), 32'(wake_mask));
                    check_field("block_forever", 32'(want.unbounded), 32'(block_forever));
                    check_field("block_ticks", want.wait_left, block_ticks);
                    check_field("fill_count", 32'(want.fill), 32'(fill_count));
                    check_field("is_empty", 32'(want.empty_flag), 32'(is_empty));
                    check_field("is_full", 32'(want.full_flag), 32'(is_full));
                    replies_checked++;
                end
            end
            if (cfg_we)
            begin
                cap_reg = cfg_wdata;
                capacity_writes++;
            end
            beat_taken = start && !busy;
            if (beat_taken)
            begin
                next_reply = predict_attempt({cmd, task_req, is_retry, nonblocking,
                                              wait_forever, wait_ticks, send_data});
                status_tally[next_reply.status]++;
                expected_replies.push_back(next_reply);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. They only append to the work list.
    // ------------------------------------------------------------------------
    task automatic add_attempt(logic op, int unsigned who, logic retry, logic nonblk,
                               logic unbounded, logic [31:0] ticks, logic [31:0] data,
                               int unsigned gap);
        entry_t e;
        e.kind = ENTRY_ATTEMPT;
        e.attempt = {op, 3'(who), retry, nonblk, unbounded, ticks, data};
        e.gap = gap;
        e.cap_value = '0;
        work_list.push_back(e);
    endtask

    task automatic add_capacity(logic [4:0] value);
        entry_t e;
        e.kind = ENTRY_CAPACITY;
        e.attempt = '0;
        e.gap = 0;
        e.cap_value = value;
        work_list.push_back(e);
    endtask

    task automatic add_drain();
        entry_t e;
        e.kind = ENTRY_DRAIN;
        e.attempt = '0;
        e.gap = 0;
        e.cap_value = '0;
        work_list.push_back(e);
    endtask

    // Random traffic in chunks. Each chunk leans toward sends, toward receives or
    // neither, so the mailbox keeps swinging between full and empty and the wait
    // masks fill up and get woken. Some chunks run with no idle cycles at all.
    task automatic add_random_run(int unsigned count);
        int unsigned send_pct;
        int unsigned gap_max;
        logic [31:0] ticks;
        send_pct = 50;
        gap_max = 3;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 24 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: send_pct = 85;
                    1: send_pct = 15;
                    default: send_pct = 50;
                endcase
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            end
            case ($urandom_range(0, 7))
                0: ticks = '0;
                1: ticks = '1;
                2: ticks = $urandom_range(1, 16);
                default: ticks = $urandom;
            endcase
            add_attempt(($urandom_range(0, 99) < send_pct) ? CMD_SEND : CMD_RECV,
                        $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                        ticks, $urandom, $urandom_range(0, gap_max));
        end
    endtask

    // ------------------------------------------------------------------------
    // Timeout guard, far beyond the slowest legal run.
    // ------------------------------------------------------------------------
    initial
    begin
        #3_000_000;
        $display("Run timed out with %0d result beats still owed", expected_replies.size());
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Run control: reset, build the whole work list, wait for it to drain.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] fill_data [16];
        logic [4:0]  cap_plan [8];
        fill_data = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'h8000_0000, 32'h0000_0001, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
        // Capacity settings after the run at the reset value: the minimum, values
        // past the depth, zero, exactly the depth and a few in between.
        cap_plan = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd3, 5'd17,
                     5'($urandom_range(2, 15)), 5'd8};

        // Directed opening on an empty mailbox at the reset capacity. Receives
        // that cannot complete: would-block, an already expired wait, an endless
        // wait and a wait at the largest tick count.
        add_attempt(CMD_RECV, 0, 1'b0, 1'b1, 1'b0, 32'd5, 32'h0, $urandom_range(0, 3));
        add_attempt(CMD_RECV, 1, 1'b0, 1'b0, 1'b0, 32'd0, 32'h0, $urandom_range(0, 3));
        add_attempt(CMD_RECV, 2, 1'b0, 1'b0, 1'b1, 32'd0, 32'h0, $urandom_range(0, 3));
        add_attempt(CMD_RECV, 7, 1'b0, 1'b0, 1'b0, '1, '1, $urandom_range(0, 3));
        // Sixteen sends fill every slot once; the first one wakes the two waiting
        // receivers. Having every slot written before any capacity change keeps
        // later receives off slots that were never filled.
        for (int unsigned i = 0; i < 16; i++)
            add_attempt(CMD_SEND, i % 8, i[0], 1'b0, 1'b0, 32'd1, fill_data[i],
                        $urandom_range(0, 3));
        // Hold off until the mailbox has answered everything, then hit it full.
        add_drain();
        add_attempt(CMD_SEND, 3, 1'b0, 1'b0, 1'b1, 32'd0, 32'hDEAD_BEEF, 0);
        add_attempt(CMD_SEND, 5, 1'b0, 1'b1, 1'b0, 32'd9, 32'h1234_5678, 0);
        add_attempt(CMD_SEND, 6, 1'b0, 1'b0, 1'b0, 32'd0, 32'h0F0F_0F0F, 1);
        // A receive frees a slot and wakes the blocked sender, which retries.
        add_attempt(CMD_RECV, 4, 1'b1, 1'b0, 1'b0, 32'd3, 32'h0, 0);
        add_attempt(CMD_SEND, 3, 1'b1, 1'b0, 1'b1, 32'd0, 32'hC0DE_CAFE, 2);

        // Random traffic, first at the reset capacity, then under each setting.
        // Capacity is changed with whatever the mailbox happens to hold.
        add_random_run(181);
        for (int unsigned p = 0; p < 8; p++)
        begin
            add_capacity(cap_plan[p]);
            add_random_run(90);
            if (p == 3)
                add_drain();
            add_random_run(91);
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (work_list.size() != 0 || start || expected_replies.size() != 0)
            @(posedge clk);
        // The extra edges below catch any stray result beat.
        repeat (4) @(posedge clk);

        if (expected_replies.size() != 0)
            mismatch_count++;
        $display("Checked %0d mailbox attempts across %0d capacity writes",
                 replies_checked, capacity_writes);
        $display("Outcomes: ok %0d, would-block %0d, timeout %0d, blocked %0d",
                 status_tally[ST_OK], status_tally[ST_WOULD_BLOCK],
                 status_tally[ST_TIMEOUT], status_tally[ST_BLOCKED]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
design/bmq_pkg.sv
design/bmq_store.sv
design/blocking_message_queue.sv
design/bmq_checker.sv
dv/blocking_message_queue_tb.sv
